[rtl/core/lsh_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the 3x3 Laplacian sharpening block.
// No dependencies; every rtl/core module refers to it by scoped names.
package lsh_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W      = 8;
   localparam int GAIN_W     = 9;
   localparam int DIM_W      = 12;
   localparam int CSR_DATA_W = 12;

   // column index/address, effective width, row cursor (runs to height + 1)
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);

   localparam logic [GAIN_W-1:0] RESET_GAIN   = 9'd128;
   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 12'd480;
   localparam logic [7:0]        ROUND_HALF   = 8'h80;

   typedef enum logic [1:0] {
      CSR_KERNEL = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      KERNEL_FOUR  = 1'b0,
      KERNEL_EIGHT = 1'b1
   } kernel_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_FLUSH = 1'b1
   } mode_type;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic    mode;
      pix_type pixel_in;
   } req_type;

   typedef struct packed {
      pix_type pixel_out;
      logic    frame_last;
   } rsp_type;

   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   typedef struct packed {
      col_type left;
      col_type center;
      col_type right;
   } hood_type;

   // per-item control decided at the cursor, used one stage later
   typedef struct packed {
      logic shift;    // window takes a new column
      logic out;      // item yields a result
      logic last;     // result closes the frame
      logic lc_rep;   // left column replicates the center
      logic rc_pad;   // right column replicates the center (row tail)
      logic top_rep;  // top row replicates the middle
      logic bot_rep;  // bottom row replicates the middle
   } step_ctl_type;

   typedef struct packed {
      logic             en;
      logic             we;
      logic             par;
      logic [COL_W-1:0] addr;
   } line_cmd_type;

   typedef struct packed {
      pix_type upper;
      pix_type middle;
   } line_rd_type;

   function automatic logic [WIDTH_W-1:0] eff_width(input logic [DIM_W-1:0] v);
      logic [WIDTH_W-1:0] w;
      if (v == '0) w = WIDTH_W'(1);
      else if (v > MAX_WIDTH) w = WIDTH_W'(MAX_WIDTH);
      else w = WIDTH_W'(v);
      return w;
   endfunction

   function automatic logic [ROW_W-1:0] eff_height(input logic [DIM_W-1:0] v);
      logic [ROW_W-1:0] h;
      if (v == '0) h = ROW_W'(1);
      else if (v > MAX_HEIGHT) h = ROW_W'(MAX_HEIGHT);
      else h = ROW_W'(v);
      return h;
   endfunction

endpackage

[rtl/core/lsh_cursor.sv]
`timescale 1ns / 1ps
// Raster cursor: column/row counters, per-item control and line store commands.
// Depends on lsh_pkg.
module lsh_cursor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic [lsh_pkg::WIDTH_W-1:0] eff_w,
   input  logic [lsh_pkg::ROW_W-1:0]   eff_h,
   input  logic                        accept,
   input  lsh_pkg::req_type            req,
   output logic                        step_valid,
   output lsh_pkg::step_ctl_type       step_ctl,
   output lsh_pkg::line_cmd_type       line_cmd
);

   logic [lsh_pkg::COL_W-1:0]   col_ff, col_in;
   logic [lsh_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [lsh_pkg::WIDTH_W-1:0] col_wide;
   logic                        is_pixel, ignore, tail, last, shift, main_out;

   always_comb begin
      is_pixel = row_ff < eff_h;
      // flush items are dropped while pixels are still expected
      ignore   = is_pixel && (req.mode == lsh_pkg::MODE_FLUSH);
      tail     = (col_ff == '0) && (row_ff >= lsh_pkg::ROW_W'(2));
      last     = tail && (row_ff == eff_h + lsh_pkg::ROW_W'(1));
      shift    = row_ff <= eff_h;
      main_out = shift && (col_ff != '0) && (row_ff != '0);

      step_valid       = accept && !ignore;
      step_ctl.shift   = shift;
      step_ctl.out     = tail || main_out;
      step_ctl.last    = last;
      step_ctl.lc_rep  = main_out ? (col_ff == lsh_pkg::COL_W'(1))
                                  : (eff_w == lsh_pkg::WIDTH_W'(1));
      step_ctl.rc_pad  = tail;
      step_ctl.top_rep = row_ff <= lsh_pkg::ROW_W'(1);
      step_ctl.bot_rep = !is_pixel;

      line_cmd.en   = step_valid && shift;
      line_cmd.we   = is_pixel;
      line_cmd.par  = row_ff[0];
      line_cmd.addr = col_ff;

      col_wide = lsh_pkg::WIDTH_W'(col_ff) + lsh_pkg::WIDTH_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (step_valid) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wide >= eff_w) begin
            col_in = '0;
            row_in = row_ff + lsh_pkg::ROW_W'(1);
         end else begin
            col_in = col_wide[lsh_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      lsh_pkg::WIDTH_W'(col_ff) < eff_w)
      else $error("column cursor beyond row width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= eff_h + lsh_pkg::ROW_W'(1))
      else $error("row cursor beyond flush row");

endmodule

[rtl/core/lsh_line_store.sv]
`timescale 1ns / 1ps
// Two ping-pong line stores indexed by column; row parity picks the one written.
// Depends on lsh_pkg.
module lsh_line_store (
   input  logic                  clock,
   input  logic                  reset,
   input  lsh_pkg::line_cmd_type cmd,
   input  lsh_pkg::pix_type      wdata,
   output lsh_pkg::line_rd_type  rd
);

   lsh_pkg::pix_type mem_even [lsh_pkg::MAX_WIDTH];
   lsh_pkg::pix_type mem_odd  [lsh_pkg::MAX_WIDTH];
   lsh_pkg::pix_type even_rd_ff, odd_rd_ff;
   logic             par_ff;

   // read-first: the line being overwritten still returns the row before last
   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.we && !cmd.par) mem_even[cmd.addr] <= wdata;
         even_rd_ff <= mem_even[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.we && cmd.par) mem_odd[cmd.addr] <= wdata;
         odd_rd_ff <= mem_odd[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) par_ff <= 1'b0;
      else if (cmd.en) par_ff <= cmd.par;
   end

   always_comb begin
      rd.upper  = par_ff ? odd_rd_ff : even_rd_ff;
      rd.middle = par_ff ? even_rd_ff : odd_rd_ff;
   end

endmodule

[rtl/core/lsh_window.sv]
`timescale 1ns / 1ps
// 3x3 window of column vectors with edge replication; selects the neighborhood
// of each result into an operand register. Depends on lsh_pkg.
module lsh_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  lsh_pkg::step_ctl_type step_ctl,
   input  lsh_pkg::pix_type      step_px,
   input  lsh_pkg::line_rd_type  line_rd,
   input  logic                  op_ready,
   output logic                  s1_ready,
   output logic                  op_valid,
   output lsh_pkg::hood_type     op_hood,
   output logic                  op_last
);

   logic                  s1_valid_ff;
   lsh_pkg::step_ctl_type s1_ctl_ff;
   lsh_pkg::pix_type      s1_px_ff;
   lsh_pkg::col_type      win_ff [3];
   logic                  op_valid_ff;
   lsh_pkg::hood_type     op_hood_ff, hood_in;
   logic                  op_last_ff;
   lsh_pkg::col_type      new_col;
   logic                  op_free, s1_move;

   always_comb begin
      new_col.mid = line_rd.middle;
      new_col.top = s1_ctl_ff.top_rep ? line_rd.middle : line_rd.upper;
      new_col.bot = s1_ctl_ff.bot_rep ? line_rd.middle : s1_px_ff;

      // center is always the newest column already in the window
      hood_in.left   = s1_ctl_ff.lc_rep ? win_ff[2] : win_ff[1];
      hood_in.center = win_ff[2];
      hood_in.right  = s1_ctl_ff.rc_pad ? win_ff[2] : new_col;

      op_free  = !op_valid_ff || op_ready;
      s1_move  = s1_valid_ff && (!s1_ctl_ff.out || op_free);
      s1_ready = !s1_valid_ff || s1_move;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         op_valid_ff <= 1'b0;
         win_ff[0]   <= '0;
         win_ff[1]   <= '0;
         win_ff[2]   <= '0;
      end else begin
         if (s1_ready) s1_valid_ff <= step_valid;
         if (s1_move && s1_ctl_ff.shift) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= new_col;
         end
         if (op_free) op_valid_ff <= s1_move && s1_ctl_ff.out;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && step_valid) begin
         s1_ctl_ff <= step_ctl;
         s1_px_ff  <= step_px;
      end
      if (op_free && s1_move && s1_ctl_ff.out) begin
         op_hood_ff <= hood_in;
         op_last_ff <= s1_ctl_ff.last;
      end
   end

   assign op_valid = op_valid_ff;
   assign op_hood  = op_hood_ff;
   assign op_last  = op_last_ff;

   // only the frame's closing tail result comes without a window shift
   a_noshift_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ctl_ff.out && !s1_ctl_ff.shift |-> s1_ctl_ff.last)
      else $error("unshifted result that does not close the frame");

   a_op_hold: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff && !op_ready |=> op_valid_ff && $stable(op_hood_ff))
      else $error("operand stage lost a stalled neighborhood");

endmodule

[rtl/core/lsh_filter.sv]
`timescale 1ns / 1ps
// Laplacian with clamp, then gain, rounding and clamp into the result register.
// Depends on lsh_pkg.
module lsh_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       op_valid,
   input  lsh_pkg::hood_type          op_hood,
   input  logic                       op_last,
   input  lsh_pkg::kernel_type        kernel,
   input  logic [lsh_pkg::GAIN_W-1:0] gain,
   input  logic                       rsp_stall,
   output logic                       filt_ready,
   output logic                       rsp_valid,
   output lsh_pkg::rsp_type           rsp_payload
);

   logic               lap_valid_ff;
   lsh_pkg::pix_type   lap_ff, lap_in, ctr_ff;
   logic               lap_last_ff;
   logic               rsp_valid_ff;
   lsh_pkg::rsp_type   rsp_ff, rsp_in;
   logic [9:0]         sum4;
   logic [10:0]        sum8;
   logic signed [11:0] diff;
   logic [16:0]        prod;
   logic signed [18:0] acc;
   logic               out_free, lap_free;

   always_comb begin
      sum4 = 10'(op_hood.center.top) + 10'(op_hood.center.bot)
           + 10'(op_hood.left.mid) + 10'(op_hood.right.mid);
      sum8 = 11'(op_hood.left.top) + 11'(op_hood.left.mid) + 11'(op_hood.left.bot)
           + 11'(op_hood.center.top) + 11'(op_hood.center.bot)
           + 11'(op_hood.right.top) + 11'(op_hood.right.mid) + 11'(op_hood.right.bot);
      if (kernel == lsh_pkg::KERNEL_EIGHT)
         diff = $signed({1'b0, sum8}) - $signed({1'b0, op_hood.center.mid, 3'b000});
      else
         diff = $signed({2'b00, sum4}) - $signed({2'b00, op_hood.center.mid, 2'b00});
      if (diff < 0) lap_in = '0;
      else if (diff > 12'sd255) lap_in = '1;
      else lap_in = diff[7:0];

      // 256*p + half - gain*lap, then floor by 256 and clamp
      prod = 17'(gain) * 17'(lap_ff);
      acc  = $signed({3'b000, ctr_ff, lsh_pkg::ROUND_HALF}) - $signed({2'b00, prod});
      if (acc[18]) rsp_in.pixel_out = '0;
      else if (acc[17:16] != 2'b00) rsp_in.pixel_out = '1;
      else rsp_in.pixel_out = acc[15:8];
      rsp_in.frame_last = lap_last_ff;

      out_free   = !rsp_valid_ff || !rsp_stall;
      lap_free   = !lap_valid_ff || out_free;
      filt_ready = lap_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (lap_free) lap_valid_ff <= op_valid;
         if (out_free) rsp_valid_ff <= lap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lap_free && op_valid) begin
         lap_ff      <= lap_in;
         ctr_ff      <= op_hood.center.mid;
         lap_last_ff <= op_last;
      end
      if (out_free && lap_valid_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_lap_hold: assert property (@(posedge clock) disable iff (reset)
      lap_valid_ff && !out_free |=> lap_valid_ff && $stable(lap_ff) && $stable(ctr_ff))
      else $error("Laplacian stage lost a stalled value");

endmodule

[rtl/core/laplacian_sharpen_3x3.sv]
`timescale 1ns / 1ps
// 3x3 Laplacian sharpening of a raster pixel stream, top level.
// Path: a transfer's result passes the stage-1, operand, Laplacian and output registers in turn;
// results lag their pixel by one row plus one pixel, and W+1 flush items close a frame.
// Throughput: one item per cycle while req_stall is low, set by the single-port read-first line stores.
// Reset (synchronous): clears counters, window, pipeline valids and restores register
// defaults; the line stores are not cleared and need no clearing pass.
module laplacian_sharpen_3x3 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lsh_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lsh_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  lsh_pkg::csr_index_type         csr_index,
   input  logic [lsh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lsh_pkg::kernel_type         kernel_ff;
   logic [lsh_pkg::GAIN_W-1:0]  gain_ff;
   logic [lsh_pkg::WIDTH_W-1:0] eff_w_ff;
   logic [lsh_pkg::ROW_W-1:0]   eff_h_ff;
   logic                        restart, accept, s1_ready;
   logic                        step_valid, op_valid, op_last, filt_ready;
   lsh_pkg::step_ctl_type       step_ctl;
   lsh_pkg::line_cmd_type       line_cmd;
   lsh_pkg::line_rd_type        line_rd;
   lsh_pkg::hood_type           op_hood;

   // a size write restarts the frame
   assign restart   = csr_we && (csr_index == lsh_pkg::CSR_WIDTH ||
                                 csr_index == lsh_pkg::CSR_HEIGHT);
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= lsh_pkg::KERNEL_FOUR;
         gain_ff   <= lsh_pkg::RESET_GAIN;
         eff_w_ff  <= lsh_pkg::eff_width(lsh_pkg::RESET_WIDTH);
         eff_h_ff  <= lsh_pkg::eff_height(lsh_pkg::RESET_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            lsh_pkg::CSR_KERNEL: kernel_ff <= lsh_pkg::kernel_type'(csr_wdata[0]);
            lsh_pkg::CSR_GAIN:   gain_ff   <= csr_wdata[lsh_pkg::GAIN_W-1:0];
            lsh_pkg::CSR_WIDTH:  eff_w_ff  <= lsh_pkg::eff_width(csr_wdata[lsh_pkg::DIM_W-1:0]);
            lsh_pkg::CSR_HEIGHT: eff_h_ff  <= lsh_pkg::eff_height(csr_wdata[lsh_pkg::DIM_W-1:0]);
            default: ;
         endcase
      end
   end

   lsh_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .eff_w      (eff_w_ff),
      .eff_h      (eff_h_ff),
      .accept     (accept),
      .req        (req_payload),
      .step_valid (step_valid),
      .step_ctl   (step_ctl),
      .line_cmd   (line_cmd)
   );

   lsh_line_store u_line_store (
      .clock (clock),
      .reset (reset),
      .cmd   (line_cmd),
      .wdata (req_payload.pixel_in),
      .rd    (line_rd)
   );

   lsh_window u_window (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_ctl   (step_ctl),
      .step_px    (req_payload.pixel_in),
      .line_rd    (line_rd),
      .op_ready   (filt_ready),
      .s1_ready   (s1_ready),
      .op_valid   (op_valid),
      .op_hood    (op_hood),
      .op_last    (op_last)
   );

   lsh_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op_hood     (op_hood),
      .op_last     (op_last),
      .kernel      (kernel_ff),
      .gain        (gain_ff),
      .rsp_stall   (rsp_stall),
      .filt_ready  (filt_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
